/* rtl/gsp_pkg.sv */
// gsp_pkg: shared types and constants of the gain-scheduled speed pid
// used by gsp_lane, gsp_outq and gain_scheduled_speed_pid
package gsp_pkg;

  localparam int unsigned LANES      = 4;
  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned ERR_W      = 17;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned LIMIT_W    = 15;
  localparam int unsigned PWM_W      = 16;
  localparam int unsigned FRAC_BITS  = 20;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 24;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_KP_LOW     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI_LOW     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD_LOW     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KP_HIGH    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KI_HIGH    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KD_HIGH    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PWM    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SWITCH_SPD = 4'd7;

  // reset values
  localparam logic [GAIN_W-1:0]  KP_LOW_RST     = 24'd393216;
  localparam logic [GAIN_W-1:0]  KI_LOW_RST     = 24'd62259;
  localparam logic [GAIN_W-1:0]  KD_LOW_RST     = 24'd0;
  localparam logic [GAIN_W-1:0]  KP_HIGH_RST    = 24'd157286;
  localparam logic [GAIN_W-1:0]  KI_HIGH_RST    = 24'd32768;
  localparam logic [GAIN_W-1:0]  KD_HIGH_RST    = 24'd0;
  localparam logic [LIMIT_W-1:0] MAX_PWM_RST    = 15'd999;
  localparam logic [LIMIT_W-1:0] SWITCH_SPD_RST = 15'd480;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
  } gain_set_t;

  typedef struct packed {
    gain_set_t          low;
    gain_set_t          high;
    logic [LIMIT_W-1:0] max_pwm;
    logic [LIMIT_W-1:0] switch_speed;
  } pid_cfg_t;

  typedef logic signed [PWM_W-1:0] pwm_t;

  typedef struct packed {
    pwm_t [LANES-1:0] pwm;
  } pwm_result_t;

endpackage

/* rtl/gsp_lane.sv */
// gsp_lane: one motor's pid core with its error sum and previous error
// depends on gsp_pkg
module gsp_lane (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic signed [gsp_pkg::SPEED_W-1:0] desired,
  input  logic signed [gsp_pkg::SPEED_W-1:0] measured,
  input  gsp_pkg::pid_cfg_t                cfg,
  output gsp_pkg::pwm_t                    pwm
);
  import gsp_pkg::*;

  localparam int unsigned P_W   = GAIN_W + 1 + ERR_W;
  localparam int unsigned I_W   = GAIN_W + 1 + SUM_W;
  localparam int unsigned D_W   = GAIN_W + 1 + ERR_W + 1;
  localparam int unsigned ACC_W = I_W + 2;
  localparam int unsigned LIM_W = LIMIT_W + FRAC_BITS + 1;

  logic signed [SUM_W-1:0] error_sum_r, error_sum_nxt;
  logic signed [ERR_W-1:0] last_error_r, last_error_nxt;

  logic signed [ERR_W-1:0]   d_ext, err;
  logic        [ERR_W-1:0]   mag;
  logic                      use_low;
  gain_set_t                 g;
  logic signed [SUM_W:0]     sum_wide;
  logic signed [SUM_W-1:0]   new_sum;
  logic signed [ERR_W:0]     diff;
  logic signed [P_W-1:0]     p_term;
  logic signed [I_W-1:0]     i_term;
  logic signed [D_W-1:0]     d_term;
  logic signed [ACC_W-1:0]   acc, lim, q;
  logic                      sat_hi, sat_lo;

  always_comb begin
    d_ext   = {desired[SPEED_W-1], desired};
    err     = d_ext - {measured[SPEED_W-1], measured};
    mag     = d_ext[ERR_W-1] ? -d_ext : d_ext;
    use_low = mag < {{(ERR_W-LIMIT_W){1'b0}}, cfg.switch_speed};
    g       = use_low ? cfg.low : cfg.high;

    // saturating 32 bit integral
    sum_wide = {error_sum_r[SUM_W-1], error_sum_r}
             + {{(SUM_W+1-ERR_W){err[ERR_W-1]}}, err};
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      new_sum = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      new_sum = sum_wide[SUM_W-1:0];
    end

    diff   = {err[ERR_W-1], err} - {last_error_r[ERR_W-1], last_error_r};
    p_term = $signed({1'b0, g.kp}) * err;
    i_term = $signed({1'b0, g.ki}) * new_sum;
    d_term = $signed({1'b0, g.kd}) * diff;

    acc = {{(ACC_W-P_W){p_term[P_W-1]}}, p_term}
        + {{(ACC_W-I_W){i_term[I_W-1]}}, i_term}
        + {{(ACC_W-D_W){d_term[D_W-1]}}, d_term};
    lim = {{(ACC_W-LIM_W){1'b0}}, 1'b0, cfg.max_pwm, {FRAC_BITS{1'b0}}};

    sat_hi = acc >= lim;
    sat_lo = acc <= -lim;

    // divide by 2^20 rounding toward zero
    q = acc >>> FRAC_BITS;
    if (acc[ACC_W-1] && (|acc[FRAC_BITS-1:0])) begin
      q = q + ACC_W'(1);
    end

    error_sum_nxt  = error_sum_r;
    last_error_nxt = err;
    if (desired == '0) begin
      pwm            = '0;
      error_sum_nxt  = '0;
      last_error_nxt = '0;
    end else if (sat_hi) begin
      pwm = pwm_t'({1'b0, cfg.max_pwm});
    end else if (sat_lo) begin
      pwm = -pwm_t'({1'b0, cfg.max_pwm});
    end else begin
      pwm           = q[PWM_W-1:0];
      error_sum_nxt = new_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r  <= '0;
      last_error_r <= '0;
    end else if (en) begin
      error_sum_r  <= error_sum_nxt;
      last_error_r <= last_error_nxt;
    end
  end

endmodule

/* rtl/gsp_outq.sv */
// gsp_outq: queues the lane results as one request and holds up to two
// depends on gsp_pkg
module gsp_outq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  gsp_pkg::pwm_result_t  push_data,
  output logic                  can_push,
  output logic                  out_valid,
  input  logic                  out_ready,
  output gsp_pkg::pwm_result_t  out_data
);
  import gsp_pkg::*;

  logic [1:0]  count_r, count_nxt;
  pwm_result_t head_r, head_nxt;
  pwm_result_t tail_r, tail_nxt;
  logic        pop;

  assign can_push  = count_r != 2'd2;
  assign out_valid = count_r != 2'd0;
  assign out_data  = head_r;
  assign pop       = out_valid && out_ready;

  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    unique case (count_r)
      2'd0: begin
        if (push) begin
          head_nxt  = push_data;
          count_nxt = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head_nxt = push_data;
        end else if (push) begin
          tail_nxt  = push_data;
          count_nxt = 2'd2;
        end else if (pop) begin
          count_nxt = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          head_nxt  = tail_r;
          count_nxt = 2'd1;
        end
      end
      default: begin
        count_nxt = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

endmodule

/* rtl/gain_scheduled_speed_pid.sv */
// gain_scheduled_speed_pid: four-motor speed pid with gain scheduling and anti-windup
// depends on gsp_pkg, gsp_lane, gsp_outq
//
//  port group   dir  handshake            payload
//  in_*         in   in_valid/in_ready    desired_0..3, measured_0..3 (s16 q12.4)
//  out_*        out  out_valid/out_ready  pwm_0..3 (s16)
//  cfg_*        in   cfg_we               cfg_index, cfg_wdata
//
// one request per cycle while in_ready is high; all lanes compute and update their
// state in the cycle a request is taken, which also pushes the result into the queue
// the per-motor state loop (multiply, sum, limit compare) sets the cycle time
// in_ready depends only on queue occupancy: two results may wait on out_ready
// synchronous active-low reset clears state and the queue and reloads the reset gains
module gain_scheduled_speed_pid #(
  parameter int unsigned NUM_MOTORS = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [gsp_pkg::SPEED_W-1:0]  in_desired_0,
  input  logic signed [gsp_pkg::SPEED_W-1:0]  in_desired_1,
  input  logic signed [gsp_pkg::SPEED_W-1:0]  in_desired_2,
  input  logic signed [gsp_pkg::SPEED_W-1:0]  in_desired_3,
  input  logic signed [gsp_pkg::SPEED_W-1:0]  in_measured_0,
  input  logic signed [gsp_pkg::SPEED_W-1:0]  in_measured_1,
  input  logic signed [gsp_pkg::SPEED_W-1:0]  in_measured_2,
  input  logic signed [gsp_pkg::SPEED_W-1:0]  in_measured_3,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [gsp_pkg::PWM_W-1:0]    out_pwm_0,
  output logic signed [gsp_pkg::PWM_W-1:0]    out_pwm_1,
  output logic signed [gsp_pkg::PWM_W-1:0]    out_pwm_2,
  output logic signed [gsp_pkg::PWM_W-1:0]    out_pwm_3,
  input  logic                                cfg_we,
  input  logic [gsp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gsp_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import gsp_pkg::*;

  pid_cfg_t    cfg_r, cfg_nxt;
  logic        accept;
  logic        can_push;
  pwm_result_t lane_res, out_res;
  logic signed [SPEED_W-1:0] desired [LANES];
  logic signed [SPEED_W-1:0] measured [LANES];

  assign desired[0]  = in_desired_0;
  assign desired[1]  = in_desired_1;
  assign desired[2]  = in_desired_2;
  assign desired[3]  = in_desired_3;
  assign measured[0] = in_measured_0;
  assign measured[1] = in_measured_1;
  assign measured[2] = in_measured_2;
  assign measured[3] = in_measured_3;

  assign in_ready = can_push;
  assign accept   = in_valid && can_push;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_KP_LOW:     cfg_nxt.low.kp       = cfg_wdata[GAIN_W-1:0];
        REG_KI_LOW:     cfg_nxt.low.ki       = cfg_wdata[GAIN_W-1:0];
        REG_KD_LOW:     cfg_nxt.low.kd       = cfg_wdata[GAIN_W-1:0];
        REG_KP_HIGH:    cfg_nxt.high.kp      = cfg_wdata[GAIN_W-1:0];
        REG_KI_HIGH:    cfg_nxt.high.ki      = cfg_wdata[GAIN_W-1:0];
        REG_KD_HIGH:    cfg_nxt.high.kd      = cfg_wdata[GAIN_W-1:0];
        REG_MAX_PWM:    cfg_nxt.max_pwm      = cfg_wdata[LIMIT_W-1:0];
        REG_SWITCH_SPD: cfg_nxt.switch_speed = cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low.kp       <= KP_LOW_RST;
      cfg_r.low.ki       <= KI_LOW_RST;
      cfg_r.low.kd       <= KD_LOW_RST;
      cfg_r.high.kp      <= KP_HIGH_RST;
      cfg_r.high.ki      <= KI_HIGH_RST;
      cfg_r.high.kd      <= KD_HIGH_RST;
      cfg_r.max_pwm      <= MAX_PWM_RST;
      cfg_r.switch_speed <= SWITCH_SPD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  for (genvar m = 0; m < LANES; m++) begin : g_lane
    if (m < NUM_MOTORS) begin : g_on
      gsp_lane u_lane (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (accept),
        .desired  (desired[m]),
        .measured (measured[m]),
        .cfg      (cfg_r),
        .pwm      (lane_res.pwm[m])
      );
    end else begin : g_off
      // absent motors report zero
      assign lane_res.pwm[m] = '0;
    end
  end

  gsp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (lane_res),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign out_pwm_0 = out_res.pwm[0];
  assign out_pwm_1 = out_res.pwm[1];
  assign out_pwm_2 = out_res.pwm[2];
  assign out_pwm_3 = out_res.pwm[3];

endmodule
